@@ rtl/aap_pkg.sv @@
// Shared op codes, Q2.30 coefficients and rounding helpers for the activation pipeline.
`default_nettype none
package aap_pkg;

	typedef enum logic [1:0] {
		OP_GELU = 2'd0,
		OP_ERF  = 2'd1,
		OP_TANH = 2'd2,
		OP_COMP = 2'd3
	} op_t;

	localparam longint Q30_ONE = 64'sd1073741824;

	// Q2.30 multipliers, rounded to nearest from six decimals
	localparam logic signed [31:0] C_SIX     = 32'((64'sd600000 * Q30_ONE + 64'sd500000) / 64'sd1000000);
	localparam logic signed [31:0] C_GATE    = 32'((64'sd306923 * Q30_ONE + 64'sd500000) / 64'sd1000000);
	localparam logic signed [31:0] C_GSCALE  = 32'((64'sd997729 * Q30_ONE + 64'sd500000) / 64'sd1000000);
	localparam logic signed [31:0] C_ERF_N   = 32'((64'sd34298 * Q30_ONE + 64'sd500000) / 64'sd1000000);
	localparam logic signed [31:0] C_ERF_D   = 32'((64'sd378089 * Q30_ONE + 64'sd500000) / 64'sd1000000);
	localparam logic signed [31:0] C_ERF_OUT = 32'((64'sd1106774 * Q30_ONE + 64'sd500000) / 64'sd1000000);
	localparam logic signed [31:0] C_TNH_N   = 32'((64'sd53639 * Q30_ONE + 64'sd500000) / 64'sd1000000);
	localparam logic signed [31:0] C_TNH_D   = 32'((64'sd343141 * Q30_ONE + 64'sd500000) / 64'sd1000000);
	localparam logic signed [31:0] C_TNH_OUT = 32'((64'sd900021 * Q30_ONE + 64'sd500000) / 64'sd1000000);

	// micro-units to fixed point with f fraction bits, round to nearest
	function automatic longint kf(input longint m, input int unsigned f);
		return (m * (64'sd1 <<< f) + 64'sd500000) / 64'sd1000000;
	endfunction

	// add half, then floor shift
	function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v,
		input int unsigned n);
		return (v + (64'sd1 <<< (n - 1))) >>> n;
	endfunction

endpackage
`default_nettype wire

@@ rtl/activation_approx_pipeline_core.sv @@
// Approximate activation unit: GELU, erf, tanh and the composite workload, fully pipelined.
//
// Input stream: s_axis_tuser carries the op code (gelu, erf, tanh, composite),
// s_axis_tdata the signed fixed-point sample. Output stream: m_axis_tdata holds
// the signed result with FRAC_BITS fraction bits.
// One request is taken per clock while s_axis_tready is high. Every op runs
// the same path, so results leave in request order. The path is an input
// stage, three rational units in series (composite: erf then tanh then erf,
// with gelu running beside the first) and two summing stages.
// Each rational unit is a clamp, three multiply stages, an FRAC_BITS+3 stage
// restoring divider, then sign and output scale: FRAC_BITS+9 stages.
// The output register is backed by a one-entry skid register: a stalled
// receiver still lets the pipeline advance until one more request lands in the
// skid, then s_axis_tready drops until the skid drains. A stall freezes all
// stages at once.
// Reset clears the pipeline valid bits and the output and skid valid flags;
// data registers, including the output and skid data, are not reset.
`default_nettype none
module activation_approx_pipeline_core #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [23:0] s_axis_tdata,  // [23:0] x_value
	input  wire logic [1:0]  s_axis_tuser,  // [1:0] op
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [31:0]      m_axis_tdata   // [31:0] y_value
);
	localparam int F    = FRAC_BITS;
	localparam int VW   = (F + 3 > 25) ? F + 3 : 25;
	localparam int IW   = VW + 1;
	localparam int SW   = VW + 2;
	localparam int OW   = F + 3;
	localparam int UW   = F + 2;
	localparam int RL   = F + 9;   // rational unit stage count
	localparam int SA   = 1 + RL;  // g and e ready
	localparam int SB   = SA + RL; // c, h, p ready
	localparam int SC   = SB + RL; // k ready
	localparam int LAST = SC + 2;

	localparam longint K_GATE_OFS = aap_pkg::kf(64'sd501000, F);
	localparam longint K_GATE_MAX = aap_pkg::kf(64'sd1002000, F);
	localparam longint K_GELU_OFS = aap_pkg::kf(64'sd4004, F);

	logic en;
	logic skid_v_q;
	logic out_v_q;
	logic push;

	assign en            = !skid_v_q;
	assign s_axis_tready = en;

	logic [LAST:1]   valid_s;
	aap_pkg::op_t    op_s [1:SC+1];
	logic signed [23:0] x_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else if (en) begin
			valid_s <= {valid_s[LAST-1:1], s_axis_tvalid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s[1] <= aap_pkg::op_t'(s_axis_tuser);
			x_s1    <= $signed(s_axis_tdata);
			for (int i = 2; i <= SC + 1; i++) begin
				op_s[i] <= op_s[i-1];
			end
		end
	end

	// gelu path, stages 2..5
	logic signed [55:0]      p_x6;
	logic signed [VW-1:0]    gin_s2;
	logic signed [VW+31:0]   p_gate;
	logic signed [63:0]      gate;
	logic signed [63:0]      u;
	logic signed [UW-1:0]    u_s3;
	logic signed [VW-1:0]    gin_s3;
	logic signed [VW+UW-1:0] p_t;
	logic signed [VW-1:0]    t_s4;
	logic signed [VW+31:0]   p_g;
	logic signed [VW-1:0]    g_s5;

	assign p_x6   = x_s1 * aap_pkg::C_SIX;
	assign p_gate = gin_s2 * aap_pkg::C_GATE;
	assign gate   = aap_pkg::rnd_shift(64'(p_gate), 30) + K_GATE_OFS;
	assign u      = (gate < 0) ? 64'sd0 : ((gate > K_GATE_MAX) ? K_GATE_MAX : gate);
	assign p_t    = gin_s3 * u_s3;
	assign p_g    = t_s4 * aap_pkg::C_GSCALE;

	always_ff @(posedge clk) begin
		if (en) begin
			gin_s2 <= (op_s[1] == aap_pkg::OP_COMP) ?
				VW'(aap_pkg::rnd_shift(64'(p_x6), 30)) : VW'(x_s1);
			u_s3   <= UW'(u);
			gin_s3 <= gin_s2;
			t_s4   <= VW'(aap_pkg::rnd_shift(64'(p_t), F));
			g_s5   <= VW'(aap_pkg::rnd_shift(64'(p_g), 30) - K_GELU_OFS);
		end
	end

	// erf(x), or tanh(x) for the tanh op
	logic signed [OW-1:0] e_raw;
	logic signed [VW-1:0] e_sa;

	aap_rat #(.FRAC_BITS(F), .IW(IW)) u_rat_e (
		.clk     (clk),
		.en      (en),
		.is_tanh (op_s[1] == aap_pkg::OP_TANH),
		.arg     (IW'(x_s1)),
		.res     (e_raw)
	);

	assign e_sa = VW'(e_raw);

	localparam int NG = RL - 4;
	logic signed [VW-1:0] g_dl [NG];
	logic signed [VW-1:0] g_sa;

	always_ff @(posedge clk) begin
		if (en) begin
			g_dl[0] <= g_s5;
			for (int i = 1; i < NG; i++) begin
				g_dl[i] <= g_dl[i-1];
			end
		end
	end

	assign g_sa = g_dl[NG-1];

	// result of the single-function ops, held until the composite finishes
	localparam int NE = SC + 1 - SA;
	logic signed [VW-1:0] early_dl [NE];

	always_ff @(posedge clk) begin
		if (en) begin
			early_dl[0] <= (op_s[SA] == aap_pkg::OP_GELU) ? g_sa : e_sa;
			for (int i = 1; i < NE; i++) begin
				early_dl[i] <= early_dl[i-1];
			end
		end
	end

	// second rank: c = tanh(g+e), h = tanh(e-g), p = erf(g/2)
	logic signed [OW-1:0] c_raw;
	logic signed [OW-1:0] h_raw;
	logic signed [OW-1:0] p_raw;
	logic signed [IW-1:0] g_half;

	assign g_half = IW'(aap_pkg::rnd_shift(64'(g_sa), 1));

	aap_rat #(.FRAC_BITS(F), .IW(IW)) u_rat_c (
		.clk     (clk),
		.en      (en),
		.is_tanh (1'b1),
		.arg     (IW'(g_sa) + IW'(e_sa)),
		.res     (c_raw)
	);

	aap_rat #(.FRAC_BITS(F), .IW(IW)) u_rat_h (
		.clk     (clk),
		.en      (en),
		.is_tanh (1'b1),
		.arg     (IW'(e_sa) - IW'(g_sa)),
		.res     (h_raw)
	);

	aap_rat #(.FRAC_BITS(F), .IW(IW)) u_rat_p (
		.clk     (clk),
		.en      (en),
		.is_tanh (1'b0),
		.arg     (g_half),
		.res     (p_raw)
	);

	logic signed [VW-1:0] ge_dl_g [RL];
	logic signed [VW-1:0] ge_dl_e [RL];
	logic signed [VW-1:0] g_sb;
	logic signed [VW-1:0] e_sb;
	logic signed [VW-1:0] c_sb;
	logic signed [VW-1:0] f_sb;

	always_ff @(posedge clk) begin
		if (en) begin
			ge_dl_g[0] <= g_sa;
			ge_dl_e[0] <= e_sa;
			for (int i = 1; i < RL; i++) begin
				ge_dl_g[i] <= ge_dl_g[i-1];
				ge_dl_e[i] <= ge_dl_e[i-1];
			end
		end
	end

	assign g_sb = ge_dl_g[RL-1];
	assign e_sb = ge_dl_e[RL-1];
	assign c_sb = VW'(c_raw);
	assign f_sb = (g_sb > c_sb) ? g_sb : c_sb;

	// third rank: k = erf(c+f)
	logic signed [OW-1:0] k_raw;

	aap_rat #(.FRAC_BITS(F), .IW(IW)) u_rat_k (
		.clk     (clk),
		.en      (en),
		.is_tanh (1'b0),
		.arg     (IW'(c_sb) + IW'(f_sb)),
		.res     (k_raw)
	);

	// max(g*e, c*f) alongside
	logic signed [2*VW-1:0] p_ge;
	logic signed [2*VW-1:0] p_cf;
	logic signed [VW-1:0]   ge_sb1;
	logic signed [VW-1:0]   cf_sb1;
	logic signed [VW-1:0]   m_sb2;

	assign p_ge = g_sb * e_sb;
	assign p_cf = c_sb * f_sb;

	always_ff @(posedge clk) begin
		if (en) begin
			ge_sb1 <= VW'(aap_pkg::rnd_shift(64'(p_ge), F));
			cf_sb1 <= VW'(aap_pkg::rnd_shift(64'(p_cf), F));
			m_sb2  <= (ge_sb1 > cf_sb1) ? ge_sb1 : cf_sb1;
		end
	end

	localparam int NM = RL - 2;
	logic signed [VW-1:0] m_dl [NM];
	logic signed [VW-1:0] h_dl [RL];
	logic signed [VW-1:0] p_dl [RL];

	always_ff @(posedge clk) begin
		if (en) begin
			m_dl[0] <= m_sb2;
			h_dl[0] <= VW'(h_raw);
			p_dl[0] <= VW'(p_raw);
			for (int i = 1; i < NM; i++) begin
				m_dl[i] <= m_dl[i-1];
			end
			for (int i = 1; i < RL; i++) begin
				h_dl[i] <= h_dl[i-1];
				p_dl[i] <= p_dl[i-1];
			end
		end
	end

	// final sum h*k + p + m
	logic signed [VW+OW-1:0] p_hk;
	logic signed [VW-1:0]    hk_sc1;
	logic signed [IW-1:0]    pm_sc1;
	logic signed [31:0]      y_sc2;

	assign p_hk = h_dl[RL-1] * k_raw;

	always_ff @(posedge clk) begin
		if (en) begin
			hk_sc1 <= VW'(aap_pkg::rnd_shift(64'(p_hk), F));
			pm_sc1 <= IW'(p_dl[RL-1]) + IW'(m_dl[NM-1]);
			// result range stays within SW bits, so the 32-bit limits are never reached
			y_sc2  <= (op_s[SC+1] == aap_pkg::OP_COMP) ?
				32'(SW'(hk_sc1) + SW'(pm_sc1)) : 32'(early_dl[NE-1]);
		end
	end

	// output register plus one-entry skid
	logic [31:0] out_q;
	logic [31:0] skid_q;

	assign push = en && valid_s[LAST];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (out_v_q && !m_axis_tready) begin
			if (push) begin
				skid_v_q <= 1'b1;
			end
		end else if (skid_v_q) begin
			out_v_q  <= 1'b1;
			skid_v_q <= 1'b0;
		end else begin
			out_v_q <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (out_v_q && !m_axis_tready) begin
			if (push) begin
				skid_q <= y_sc2;
			end
		end else if (skid_v_q) begin
			out_q <= skid_q;
		end else if (push) begin
			out_q <= y_sc2;
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = out_q;

endmodule
`default_nettype wire

@@ rtl/aap_rat.sv @@
// Pipelined rational cubic (erf or tanh) with a restoring divider, one quotient bit per stage.
`default_nettype none
module aap_rat #(
	parameter int FRAC_BITS = 16,
	parameter int IW        = 26
) (
	input  wire logic                        clk,
	input  wire logic                        en,
	input  wire logic                        is_tanh,
	input  wire logic signed [IW-1:0]        arg,
	output logic signed [FRAC_BITS+2:0]      res
);
	localparam int F    = FRAC_BITS;
	localparam int YW   = F + 3;
	localparam int Y2W  = F + 5;
	localparam int Y3W  = F + 6;
	localparam int DW   = F + 3;
	localparam int NUMW = F + 4;
	localparam int QW   = F + 3;
	localparam int NW   = 2 * F + 4;
	localparam int SQW  = F + 4;
	localparam int OW   = F + 3;

	localparam logic signed [IW-1:0] LIM_E = IW'(aap_pkg::kf(64'sd2000000, F));
	localparam logic signed [IW-1:0] LIM_T = IW'(aap_pkg::kf(64'sd3000000, F));
	localparam logic [DW-1:0] KDEN_E = DW'(aap_pkg::kf(64'sd995000, F));
	localparam logic [DW-1:0] KDEN_T = DW'(aap_pkg::kf(64'sd901220, F));

	// s1: clamp
	logic signed [IW-1:0] lim;
	logic signed [YW-1:0] yc;
	logic signed [YW-1:0] y_s1;
	logic                 th_s1;

	assign lim = is_tanh ? LIM_T : LIM_E;

	always_comb begin
		if (arg > lim) begin
			yc = YW'(lim);
		end else if (arg < -lim) begin
			yc = YW'(-lim);
		end else begin
			yc = YW'(arg);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			y_s1  <= yc;
			th_s1 <= is_tanh;
		end
	end

	// s2: square
	logic signed [2*YW-1:0] p_yy;
	logic signed [Y2W-1:0]  y2_s2;
	logic signed [YW-1:0]   y_s2;
	logic                   th_s2;

	assign p_yy = y_s1 * y_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			y2_s2 <= Y2W'(aap_pkg::rnd_shift(64'(p_yy), F));
			y_s2  <= y_s1;
			th_s2 <= th_s1;
		end
	end

	// s3: cube and denominator
	logic signed [Y2W+YW-1:0] p_y3;
	logic signed [Y2W+31:0]   p_den;
	logic signed [Y3W-1:0]    y3_s3;
	logic [DW-1:0]            den_s3;
	logic signed [YW-1:0]     y_s3;
	logic                     th_s3;

	assign p_y3  = y2_s2 * y_s2;
	assign p_den = y2_s2 * (th_s2 ? aap_pkg::C_TNH_D : aap_pkg::C_ERF_D);

	always_ff @(posedge clk) begin
		if (en) begin
			y3_s3  <= Y3W'(aap_pkg::rnd_shift(64'(p_y3), F));
			den_s3 <= (th_s2 ? KDEN_T : KDEN_E) + DW'(aap_pkg::rnd_shift(64'(p_den), 30));
			y_s3   <= y_s2;
			th_s3  <= th_s2;
		end
	end

	// s4: numerator, magnitude, rounding bias for the quotient
	logic signed [Y3W+31:0] p_num;
	logic signed [NUMW-1:0] num;
	logic [NUMW-2:0]        mag;

	assign p_num = y3_s3 * (th_s3 ? aap_pkg::C_TNH_N : aap_pkg::C_ERF_N);
	assign num   = NUMW'(y_s3) + NUMW'(aap_pkg::rnd_shift(64'(p_num), 30));
	assign mag   = (NUMW-1)'(num[NUMW-1] ? -num : num);

	logic [NW-1:0] rem_d [QW];
	logic [DW-1:0] den_d [QW];
	logic [QW-1:0] q_d   [1:QW];
	logic          neg_d [QW+1];
	logic          th_d  [QW+1];

	always_ff @(posedge clk) begin
		if (en) begin
			rem_d[0] <= (NW'(mag) << F) + NW'(den_s3 >> 1);
			den_d[0] <= den_s3;
			neg_d[0] <= num[NUMW-1];
			th_d[0]  <= th_s3;
		end
	end

	// divider: stage j resolves quotient bit QW-1-j
	for (genvar j = 0; j < QW; j++) begin : g_div
		localparam int B = QW - 1 - j;
		logic [NW+1:0] dsh;
		logic          ok;

		assign dsh = (NW+2)'(den_d[j]) << B;
		assign ok  = {2'b00, rem_d[j]} >= dsh;

		always_ff @(posedge clk) begin
			if (en) begin
				neg_d[j+1] <= neg_d[j];
				th_d[j+1]  <= th_d[j];
			end
		end

		if (j == 0) begin : g_first
			always_ff @(posedge clk) begin
				if (en) begin
					q_d[1] <= QW'(ok) << B;
				end
			end
		end else begin : g_next
			always_ff @(posedge clk) begin
				if (en) begin
					q_d[j+1] <= q_d[j] | (QW'(ok) << B);
				end
			end
		end

		if (j < QW - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					rem_d[j+1] <= ok ? NW'(rem_d[j] - dsh[NW-1:0]) : rem_d[j];
					den_d[j+1] <= den_d[j];
				end
			end
		end
	end

	// s5 and s6 follow the divider: sign, then output scale
	logic signed [SQW-1:0]  sq_s5;
	logic                   th_s5;
	logic signed [SQW+31:0] p_res;
	logic signed [OW-1:0]   res_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s5 <= neg_d[QW] ? -$signed({1'b0, q_d[QW]}) : $signed({1'b0, q_d[QW]});
			th_s5 <= th_d[QW];
		end
	end

	assign p_res = sq_s5 * (th_s5 ? aap_pkg::C_TNH_OUT : aap_pkg::C_ERF_OUT);

	always_ff @(posedge clk) begin
		if (en) begin
			res_s6 <= OW'(aap_pkg::rnd_shift(64'(p_res), 30));
		end
	end

	assign res = res_s6;

endmodule
`default_nettype wire

@@ rtl/aap_checker.sv @@
// Port-level checks of the output skid and request flow control.
`default_nettype none
module aap_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tready,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [31:0] m_axis_tdata
);

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result changed");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("not ready with empty output");

	a_skid_drain: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready && m_axis_tready |=> s_axis_tready)
		else $error("skid did not drain");

	a_ready_fall: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(s_axis_tready) |-> $past(m_axis_tvalid && !m_axis_tready))
		else $error("ready dropped without an output stall");

endmodule

bind activation_approx_pipeline_core aap_checker u_aap_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
